### hdl/idb_pkg.sv
// Package with shared widths, command codes and status codes of the indexed deque buffer.
package idb_pkg;

    // Fixed field widths.
    localparam int POS_W  = 10;
    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int ST_W   = 2;

    // Command codes carried by each input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_GET        = 3'd4,
        CMD_SET        = 3'd5,
        CMD_COUNT      = 3'd6
    } t_cmd;

    // Result status codes.
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

### hdl/idb_ram.sv
// Generic single-port synchronous RAM with a registered read port.
module idb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle; read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/indexed_deque_buffer_top.sv
// Top level of the indexed deque buffer: pointer logic, ring memory and result pipeline.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_cmd, i_position, i_word_in
//  out     | output    | o_out_valid / i_out_ready| o_word_out, o_occupancy, o_status
//
//  One item per cycle while the output is not stalled; each item makes at most one access to the single RAM port.
//  An accepted item passes through the RAM read stage and then the output register before its result appears.
//  Reset clears the front pointer, the count and the pipeline valid bits; the RAM is not cleared.
//  A stalled output register holds the read stage, which in turn drops o_in_ready.
module indexed_deque_buffer_top
    import idb_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [CMD_W-1:0]                   i_cmd,
    input  logic [POS_W-1:0]                   i_position,
    input  logic [WORD_W-1:0]                  i_word_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [WORD_W-1:0]                  o_word_out,
    output logic [$clog2(CAPACITY+1)-1:0]      o_occupancy,
    output logic [ST_W-1:0]                    o_status
);

    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [PTR_W:0]   CAP_S   = (PTR_W + 1)'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_SL = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // Architectural state.
    logic [PTR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;

    // Read stage and output register.
    logic             r_s1_valid;
    logic             r_s1_rd;
    logic [CNT_W-1:0] r_s1_occ;
    t_status          r_s1_status;
    logic             r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [CNT_W-1:0] r_out_occ;
    t_status          r_out_status;

    logic             in_acc;
    logic             s1_move;
    t_cmd             cmd;
    t_status          n_status;
    logic             n_rd;
    logic             ram_we;
    logic             ram_re;
    logic [PTR_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_rdata;
    logic             full;
    logic             empty;
    logic             in_range;
    logic [PTR_W-1:0] lidx;
    logic [PTR_W:0]   slot_sum;
    logic [PTR_W-1:0] slot;
    logic [PTR_W-1:0] front_dec;
    logic [PTR_W-1:0] front_inc;

    // Pipeline handshakes.
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;
    assign cmd        = t_cmd'(i_cmd);

    // Occupancy and range checks.
    assign full     = (r_count == CAP_C);
    assign empty    = (r_count == '0);
    assign in_range = (WIDE_W'(i_position) < WIDE_W'(r_count));

    // Logical index to physical slot; both terms stay below the capacity.
    always_comb begin
        case (cmd)
            CMD_PUSH_BACK: lidx = r_count[PTR_W-1:0];
            CMD_POP_BACK:  lidx = PTR_W'(r_count - ONE_C);
            CMD_GET,
            CMD_SET:       lidx = PTR_W'(i_position);
            default:       lidx = '0;
        endcase
    end

    assign slot_sum  = {1'b0, r_front} + {1'b0, lidx};
    assign slot      = (slot_sum >= CAP_S) ? PTR_W'(slot_sum - CAP_S) : slot_sum[PTR_W-1:0];
    assign front_dec = (r_front == '0) ? LAST_SL : PTR_W'(r_front - 1'b1);
    assign front_inc = (r_front == LAST_SL) ? '0 : PTR_W'(r_front + 1'b1);

    // Command decode: status, memory access and next pointer state.
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_OK;
        n_rd     = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = slot;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we   = in_acc;
                    ram_addr = front_dec;
                    n_front  = front_dec;
                    n_count  = r_count + ONE_C;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we  = in_acc;
                    n_count = r_count + ONE_C;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ram_re  = in_acc;
                    n_rd    = 1'b1;
                    n_front = front_inc;
                    n_count = r_count - ONE_C;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ram_re  = in_acc;
                    n_rd    = 1'b1;
                    n_count = r_count - ONE_C;
                end
            end
            CMD_GET: begin
                if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    ram_re = in_acc;
                    n_rd   = 1'b1;
                end
            end
            CMD_SET: begin
                if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    ram_we = in_acc;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Ring memory.
    idb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_word_in),
        .o_rdata (ram_rdata)
    );

    // Pointer, count and valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (o_in_ready) begin
                r_s1_valid <= in_acc;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Read stage and output payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rd     <= n_rd;
            r_s1_occ    <= n_count;
            r_s1_status <= n_status;
        end
        if (s1_move) begin
            r_out_word   <= r_s1_rd ? ram_rdata : '0;
            r_out_occ    <= r_s1_occ;
            r_out_status <= r_s1_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word_out  = r_out_word;
    assign o_occupancy = r_out_occ;
    assign o_status    = r_out_status;

`ifndef SYNTHESIS
    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("stored count exceeds capacity");

    // A rejected command leaves pointer and count untouched.
    a_reject_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (n_status != ST_OK) |=> $stable(r_count) && $stable(r_front))
        else $error("rejected command changed state");

    // The full status is only reported at capacity.
    a_full_only_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (n_status == ST_FULL) |-> full)
        else $error("full status below capacity");

    // While the read stage is stalled the RAM is not touched, so its read data holds.
    a_stall_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |-> !ram_we && !ram_re)
        else $error("RAM accessed during read stage stall");

    // Occupancy shown on a result stays within capacity.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out_occ <= CAP_C))
        else $error("reported occupancy exceeds capacity");
`endif

endmodule
